// ===== hw/rtl/lavm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg: shared types and helpers of the look-at view matrix builder
// Fixed-point format, job record between front and back, state encodings,
// and the round-and-saturate helpers used on both sides.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int unsigned FRAC_BITS = 16;
  // quotient of one normalize division never exceeds one, so FRAC_BITS+1 bits
  localparam int unsigned QUO_W     = FRAC_BITS + 1;
  // rounded dividend: 32-bit magnitude, FRAC_BITS zeros, one carry bit
  localparam int unsigned NUM_W     = 32 + QUO_W;

  typedef logic signed [31:0] word_t;

  localparam word_t ONE = 32'sd1 <<< FRAC_BITS;

  // one classified beat from front to back
  typedef struct packed {
    word_t [2:0] e;
    word_t [2:0] r;
    word_t [2:0] s;
    word_t [2:0] t;
    logic        degen;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RUN,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCALE,
    B_SQ,
    B_SQRT,
    B_DSTART,
    B_DIV,
    B_MAC,
    B_ROW,
    B_EMIT
  } back_state_e;

  // clamp to the signed 32-bit range
  function automatic word_t sat32(input logic signed [63:0] v);
    word_t res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // drop the fraction bits, round half up, clamp
  function automatic word_t rnd_sat(input logic signed [63:0] x);
    logic signed [63:0] h;
    h = (x >>> (FRAC_BITS - 1)) + 64'sd1;
    h = h >>> 1;
    return sat32(h);
  endfunction

endpackage

// ===== hw/rtl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix: look-at view matrix builder, signed Q16.16
// Builds the 4x4 column-major view matrix from eye, target and up.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the nine coordinates and raise start; the command
//   is taken at a rising edge with start high and busy low.
//   Result channel: four beats per command, column 0 first, each shown for one
//   cycle under result_valid_o; last_column_o marks column 3. The receiver
//   cannot stall, so beats leave back to back as soon as a matrix is done.
//   Sequence: the front runs 12 multiplier steps and the hand-off, then the
//   back works each of three rows in turn: scale, three squaring steps, a
//   square root wait and three divisions with a start and an accumulate step
//   each; a degenerate basis skips these steps in the back.
//   The shared square-root and divider units in the back bound the command
//   rate; a second command is taken while the first is still in the back,
//   held in a two-entry queue.
//   Reset: clears all control state; no beats are pending afterwards.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  lavm_pkg::word_t        eye_x_i,
  input  lavm_pkg::word_t        eye_y_i,
  input  lavm_pkg::word_t        eye_z_i,
  input  lavm_pkg::word_t        target_x_i,
  input  lavm_pkg::word_t        target_y_i,
  input  lavm_pkg::word_t        target_z_i,
  input  lavm_pkg::word_t        up_x_i,
  input  lavm_pkg::word_t        up_y_i,
  input  lavm_pkg::word_t        up_z_i,
  output logic                   result_valid_o,
  output logic [1:0]             column_index_o,
  output lavm_pkg::word_t        row0_value_o,
  output lavm_pkg::word_t        row1_value_o,
  output lavm_pkg::word_t        row2_value_o,
  output lavm_pkg::word_t        row3_value_o,
  output logic                   last_column_o
);

  lavm_pkg::word_t [2:0] eye, target, up;
  lavm_pkg::job_t        push_job, pop_job;
  logic                  push, pop, full, empty;

  // gather the coordinates into vectors
  assign eye    = {eye_z_i, eye_y_i, eye_x_i};
  assign target = {target_z_i, target_y_i, target_x_i};
  assign up     = {up_z_i, up_y_i, up_x_i};

  lavm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .eye_i    (eye),
    .target_i (target),
    .up_i     (up),
    .full_i   (full),
    .push_o   (push),
    .job_o    (push_job)
  );

  lavm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (pop_job),
    .full_o  (full),
    .empty_o (empty)
  );

  lavm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .job_i          (pop_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .column_index_o (column_index_o),
    .row0_value_o   (row0_value_o),
    .row1_value_o   (row1_value_o),
    .row2_value_o   (row2_value_o),
    .row3_value_o   (row3_value_o),
    .last_column_o  (last_column_o)
  );

endmodule

// ===== hw/rtl/lavm_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_isqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module lavm_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic        done_q;
  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem2;
  logic [35:0] trial;
  logic        take;

  // trial subtract of one radix-4 digit
  assign rem2  = {rem_q, x_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign take  = rem2 >= trial;

  // sequence the 32 steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // advance remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= take ? 34'(rem2 - trial) : 34'(rem2);
      root_q <= {root_q[30:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/lavm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_div: iterative restoring divider
// Divides a dividend whose quotient fits QUO_W bits, one bit per cycle.
// ----------------------------------------------------------------------------
module lavm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lavm_pkg::NUM_W-1:0] num_i,
  input  logic [31:0]                den_i,
  output logic                       done_o,
  output logic [lavm_pkg::QUO_W-1:0] quo_o
);

  localparam int unsigned QuoW = lavm_pkg::QUO_W;
  localparam int unsigned CntW = $clog2(QuoW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [31:0]     rem_q;
  logic [31:0]     den_q;
  logic [QuoW-1:0] nb_q;
  logic [QuoW-1:0] quo_q;
  logic [32:0]     rem2;
  logic            take;

  // shift in the next dividend bit and try the subtract
  assign rem2 = {rem_q, nb_q[QuoW-1]};
  assign take = rem2 >= {1'b0, den_q};

  // sequence QUO_W steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // the upper dividend bits are already below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[lavm_pkg::NUM_W-1:QuoW];
      nb_q  <= num_i[QuoW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
      nb_q  <= {nb_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/lavm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_front: command intake and basis cross products
// Forms t = eye - target, r = up x t, s = t x r on one shared multiplier and
// flags the degenerate basis before handing the beat to the queue.
// ----------------------------------------------------------------------------
module lavm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  lavm_pkg::word_t [2:0]     eye_i,
  input  lavm_pkg::word_t [2:0]     target_i,
  input  lavm_pkg::word_t [2:0]     up_i,
  input  logic                      full_i,
  output logic                      push_o,
  output lavm_pkg::job_t            job_o
);

  lavm_pkg::front_state_e state_q, state_d;
  logic [3:0]             step_q;
  lavm_pkg::word_t [2:0]  e_q, u_q, t_q, r_q, s_q;
  lavm_pkg::word_t [2:0]  t_in;
  lavm_pkg::word_t        op_a, op_b;
  logic signed [63:0]     prod_q;
  logic signed [63:0]     mul;
  logic signed [63:0]     diff;
  logic [1:0]             sidx;
  logic                   accept;

  assign push_o = (state_q == lavm_pkg::F_PUSH) && !full_i;
  assign busy   = !((state_q == lavm_pkg::F_IDLE) || push_o);
  assign accept = start && !busy;

  // saturated difference eye - target
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_in[i] = lavm_pkg::sat32(64'(eye_i[i]) - 64'(target_i[i]));
    end
  end

  // pick the operand pair of the current step
  always_comb begin
    case (step_q)
      4'd0:    begin op_a = u_q[1]; op_b = t_q[2]; end
      4'd1:    begin op_a = u_q[2]; op_b = t_q[1]; end
      4'd2:    begin op_a = u_q[2]; op_b = t_q[0]; end
      4'd3:    begin op_a = u_q[0]; op_b = t_q[2]; end
      4'd4:    begin op_a = u_q[0]; op_b = t_q[1]; end
      4'd5:    begin op_a = u_q[1]; op_b = t_q[0]; end
      4'd6:    begin op_a = t_q[1]; op_b = r_q[2]; end
      4'd7:    begin op_a = t_q[2]; op_b = r_q[1]; end
      4'd8:    begin op_a = t_q[2]; op_b = r_q[0]; end
      4'd9:    begin op_a = t_q[0]; op_b = r_q[2]; end
      4'd10:   begin op_a = t_q[0]; op_b = r_q[1]; end
      4'd11:   begin op_a = t_q[1]; op_b = r_q[0]; end
      default: begin op_a = '0;     op_b = '0;     end
    endcase
  end

  assign mul  = 64'(op_a) * 64'(op_b);
  assign diff = prod_q - mul;
  assign sidx = 2'(step_q[3:1] - 3'd3);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lavm_pkg::F_IDLE: if (start) state_d = lavm_pkg::F_RUN;
      lavm_pkg::F_RUN:  if (step_q == 4'd11) state_d = lavm_pkg::F_PUSH;
      lavm_pkg::F_PUSH: begin
        if (!full_i) state_d = start ? lavm_pkg::F_RUN : lavm_pkg::F_IDLE;
      end
      default:          state_d = lavm_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lavm_pkg::F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
      end else if (state_q == lavm_pkg::F_RUN) begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  // capture the command, then run two steps per cross term
  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_q <= eye_i;
      u_q <= up_i;
      t_q <= t_in;
    end else if (state_q == lavm_pkg::F_RUN) begin
      if (!step_q[0]) begin
        prod_q <= mul;
      end else if (step_q < 4'd6) begin
        r_q[step_q[2:1]] <= lavm_pkg::rnd_sat(diff);
      end else begin
        s_q[sidx] <= lavm_pkg::rnd_sat(diff);
      end
    end
  end

  assign job_o.e     = e_q;
  assign job_o.r     = r_q;
  assign job_o.s     = s_q;
  assign job_o.t     = t_q;
  assign job_o.degen = (s_q == '0);

endmodule

// ===== hw/rtl/lavm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_queue: two-entry job queue
// Decouples the cross-product front from the normalizing back.
// ----------------------------------------------------------------------------
module lavm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lavm_pkg::job_t data_i,
  input  logic           pop_i,
  output lavm_pkg::job_t data_o,
  output logic           full_o,
  output logic           empty_o
);

  lavm_pkg::job_t [1:0] mem_q;
  logic                 wr_q;
  logic                 rd_q;
  logic [1:0]           cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/lavm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_back: normalize, translate and emit
// Scales each basis row to unit length with the shared square root and
// divider, forms the translation column and streams four column beats.
// ----------------------------------------------------------------------------
module lavm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  lavm_pkg::job_t        job_i,
  output logic                  pop_o,
  output logic                  result_valid_o,
  output logic [1:0]            column_index_o,
  output lavm_pkg::word_t       row0_value_o,
  output lavm_pkg::word_t       row1_value_o,
  output lavm_pkg::word_t       row2_value_o,
  output lavm_pkg::word_t       row3_value_o,
  output logic                  last_column_o
);

  localparam int unsigned QuoW = lavm_pkg::QUO_W;
  localparam int unsigned NumW = lavm_pkg::NUM_W;
  localparam int unsigned Frac = lavm_pkg::FRAC_BITS;

  lavm_pkg::back_state_e state_q, state_d;
  lavm_pkg::job_t        job_q;
  logic [1:0]            vsel_q, csel_q, col_q;
  logic [2:0][31:0]      wmag_q, wmag_d;
  logic [2:0]            wneg_q;
  logic [63:0]           sum_q, sum_d;
  logic [31:0]           len_q;
  logic signed [QuoW:0]  q_q;
  logic signed [63:0]    acc_q;
  lavm_pkg::word_t [3:0][2:0] mat_q;

  lavm_pkg::word_t [2:0] vec;
  logic [2:0][31:0]      vmag;
  logic [32:0]           vneg_ext;
  logic [31:0]           mmax;
  logic [4:0]            kshift;
  logic [63:0]           sq;
  logic                  sqrt_start, sqrt_done;
  logic [31:0]           root;
  logic                  div_start, div_done;
  logic [NumW-1:0]       num;
  logic [QuoW-1:0]       quo;
  logic [QuoW:0]         qu, qsel;

  logic                  res_valid_q;
  logic [1:0]            res_col_q;
  lavm_pkg::word_t [3:0] res_row_q;
  logic                  res_last_q;

  // select the basis row under work
  always_comb begin
    case (vsel_q)
      2'd0:    vec = job_q.r;
      2'd1:    vec = job_q.s;
      default: vec = job_q.t;
    endcase
  end

  // magnitudes, largest magnitude and exact left shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vneg_ext = 33'd0 - {vec[i][31], vec[i]};
      vmag[i]  = vec[i][31] ? vneg_ext[31:0] : vec[i];
    end
    mmax = vmag[0];
    if (vmag[1] > mmax) mmax = vmag[1];
    if (vmag[2] > mmax) mmax = vmag[2];
    kshift = '0;
    for (int i = 0; i < 31; i++) begin
      if (mmax[i]) kshift = 5'(30 - i);
    end
    if (mmax[31]) kshift = '0;
    for (int i = 0; i < 3; i++) begin
      wmag_d[i] = vmag[i] << kshift;
    end
  end

  // sum of squares, one component a cycle
  assign sq    = 64'(wmag_q[csel_q]) * 64'(wmag_q[csel_q]);
  assign sum_d = sum_q + sq;

  assign sqrt_start = (state_q == lavm_pkg::B_SQ) && (csel_q == 2'd2);
  assign div_start  = state_q == lavm_pkg::B_DSTART;
  assign num        = NumW'({wmag_q[csel_q], {Frac{1'b0}}}) + NumW'(len_q >> 1);

  lavm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sum_d),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  lavm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (len_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // a zero length leaves the component at zero
  assign qu   = (len_q == '0) ? '0 : {1'b0, quo};
  assign qsel = wneg_q[csel_q] ? ((QuoW + 1)'(0) - qu) : qu;

  assign pop_o = (state_q == lavm_pkg::B_IDLE) && !empty_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lavm_pkg::B_IDLE: begin
        if (!empty_i) state_d = job_i.degen ? lavm_pkg::B_EMIT : lavm_pkg::B_SCALE;
      end
      lavm_pkg::B_SCALE:  state_d = lavm_pkg::B_SQ;
      lavm_pkg::B_SQ:     if (csel_q == 2'd2) state_d = lavm_pkg::B_SQRT;
      lavm_pkg::B_SQRT:   if (sqrt_done) state_d = lavm_pkg::B_DSTART;
      lavm_pkg::B_DSTART: state_d = lavm_pkg::B_DIV;
      lavm_pkg::B_DIV:    if (div_done) state_d = lavm_pkg::B_MAC;
      lavm_pkg::B_MAC: begin
        state_d = (csel_q == 2'd2) ? lavm_pkg::B_ROW : lavm_pkg::B_DSTART;
      end
      lavm_pkg::B_ROW: begin
        state_d = (vsel_q == 2'd2) ? lavm_pkg::B_EMIT : lavm_pkg::B_SCALE;
      end
      lavm_pkg::B_EMIT:   if (col_q == 2'd3) state_d = lavm_pkg::B_IDLE;
      default:            state_d = lavm_pkg::B_IDLE;
    endcase
  end

  // state, counters and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lavm_pkg::B_IDLE;
      vsel_q      <= '0;
      csel_q      <= '0;
      col_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= state_q == lavm_pkg::B_EMIT;
      unique case (state_q)
        lavm_pkg::B_IDLE: begin
          vsel_q <= '0;
          col_q  <= '0;
        end
        lavm_pkg::B_SCALE: csel_q <= '0;
        lavm_pkg::B_SQ:    csel_q <= (csel_q == 2'd2) ? 2'd0 : csel_q + 2'd1;
        lavm_pkg::B_MAC:   csel_q <= (csel_q == 2'd2) ? 2'd0 : csel_q + 2'd1;
        lavm_pkg::B_ROW:   vsel_q <= vsel_q + 2'd1;
        lavm_pkg::B_EMIT:  col_q  <= col_q + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      lavm_pkg::B_IDLE: begin
        if (!empty_i) begin
          job_q <= job_i;
          for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
              mat_q[c][r] <= (c == r) ? lavm_pkg::ONE : '0;
            end
            mat_q[3][c] <= lavm_pkg::sat32(64'sd0 - 64'(job_i.e[c]));
          end
        end
      end
      lavm_pkg::B_SCALE: begin
        wmag_q <= wmag_d;
        for (int i = 0; i < 3; i++) wneg_q[i] <= vec[i][31];
        sum_q  <= '0;
        acc_q  <= '0;
      end
      lavm_pkg::B_SQ:   sum_q <= sum_d;
      lavm_pkg::B_SQRT: if (sqrt_done) len_q <= root;
      lavm_pkg::B_DIV: begin
        if (div_done) begin
          q_q                   <= $signed(qsel);
          mat_q[csel_q][vsel_q] <= 32'($signed(qsel));
        end
      end
      lavm_pkg::B_MAC:  acc_q <= acc_q + q_q * job_q.e[csel_q];
      lavm_pkg::B_ROW:  mat_q[3][vsel_q] <= lavm_pkg::rnd_sat(64'sd0 - acc_q);
      lavm_pkg::B_EMIT: begin
        res_col_q    <= col_q;
        res_row_q[0] <= mat_q[col_q][0];
        res_row_q[1] <= mat_q[col_q][1];
        res_row_q[2] <= mat_q[col_q][2];
        res_row_q[3] <= (col_q == 2'd3) ? lavm_pkg::ONE : '0;
        res_last_q   <= col_q == 2'd3;
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign column_index_o = res_col_q;
  assign row0_value_o   = res_row_q[0];
  assign row1_value_o   = res_row_q[1];
  assign row2_value_o   = res_row_q[2];
  assign row3_value_o   = res_row_q[3];
  assign last_column_o  = res_last_q;

`ifndef SYNTHESIS
  // a result beat only follows a column emit cycle
  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == lavm_pkg::B_EMIT))
    else $error("result strobe without emit");

  // never take a job from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop on empty queue");

  // a run ends with a gap before the next run starts
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_last_q) |=> !res_valid_q)
    else $error("result beat right after last column");
`endif

endmodule
